@@ rtl/ioc3_pkg.sv @@
// shared types and constants of the 3x3 outline filter
// no dependencies; used by every file of the block
package ioc3_pkg;

    // payload and configuration widths
    localparam int ColorW     = 24;
    localparam int WidthRegW  = 11;
    localparam int HeightRegW = 13;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 24;

    // default frame limits
    localparam int DefMaxWidth  = 1024;
    localparam int DefMaxHeight = 4096;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_BACKGROUND   = 2'd2,
        CFG_CONTOUR      = 2'd3
    } t_cfg_idx;

    // request codes
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // register reset values
    localparam logic [WidthRegW-1:0]  RstWidth      = 11'd16;
    localparam logic [HeightRegW-1:0] RstHeight     = 13'd16;
    localparam logic [ColorW-1:0]     RstBackground = 24'hFF00FF;
    localparam logic [ColorW-1:0]     RstContour    = 24'h000000;

    // position flags of one beat, from the counter stage to the window stage
    typedef struct packed {
        logic emit;
        logic ok_row_up;
        logic ok_row_dn;
        logic ok_col_lf;
        logic ok_col_rt;
        logic last;
    } t_pos_flags;

endpackage

@@ rtl/ioc3_line_store.sv @@
// two row stores (row above, middle row) with registered read and write forwarding
// depends on ioc3_pkg
module ioc3_line_store #(
    parameter int DEPTH = ioc3_pkg::DefMaxWidth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_idx,
    input  logic                          i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_idx,
    input  logic [ioc3_pkg::ColorW-1:0]   i_wr_top,
    input  logic [ioc3_pkg::ColorW-1:0]   i_wr_mid,
    output logic [ioc3_pkg::ColorW-1:0]   o_top,
    output logic [ioc3_pkg::ColorW-1:0]   o_mid
);

    logic [ioc3_pkg::ColorW-1:0] r_above  [DEPTH];
    logic [ioc3_pkg::ColorW-1:0] r_middle [DEPTH];
    logic [ioc3_pkg::ColorW-1:0] r_rd_top;
    logic [ioc3_pkg::ColorW-1:0] r_rd_mid;
    logic [ioc3_pkg::ColorW-1:0] r_fwd_top;
    logic [ioc3_pkg::ColorW-1:0] r_fwd_mid;
    logic                        r_fwd;
    logic                        n_fwd;

    // a write at the same edge and address as a read must be seen by that read
    assign n_fwd = i_wr_en && (i_wr_idx == i_rd_idx);

    // memory arrays: one write and one read address per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_above[i_wr_idx]  <= i_wr_top;
            r_middle[i_wr_idx] <= i_wr_mid;
        end
        if (i_rd_en) begin
            r_rd_top  <= r_above[i_rd_idx];
            r_rd_mid  <= r_middle[i_rd_idx];
            r_fwd_top <= i_wr_top;
            r_fwd_mid <= i_wr_mid;
        end
    end

    // forwarding select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= n_fwd;
        end
    end

    assign o_top = r_fwd ? r_fwd_top : r_rd_top;
    assign o_mid = r_fwd ? r_fwd_mid : r_rd_mid;

endmodule

@@ rtl/ioc3_window.sv @@
// 3x3 pixel window and the outline decision on the window after its shift
// depends on ioc3_pkg
module ioc3_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [ioc3_pkg::ColorW-1:0]   i_top,
    input  logic [ioc3_pkg::ColorW-1:0]   i_mid,
    input  logic [ioc3_pkg::ColorW-1:0]   i_data,
    input  ioc3_pkg::t_pos_flags          i_flags,
    input  logic [ioc3_pkg::ColorW-1:0]   i_background,
    input  logic [ioc3_pkg::ColorW-1:0]   i_contour,
    output logic [ioc3_pkg::ColorW-1:0]   o_pixel,
    output logic                          o_draw
);

    logic [ioc3_pkg::ColorW-1:0] r_win [9];
    logic [ioc3_pkg::ColorW-1:0] n_win [9];
    logic [2:0]                  ok_row;
    logic [2:0]                  ok_col;
    logic [8:0]                  hit;
    logic [ioc3_pkg::ColorW-1:0] center;

    // shift one column left and take the new right column
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]     = r_win[r*3+1];
            n_win[r*3 + 1] = r_win[r*3+2];
        end
        n_win[2] = i_top;
        n_win[5] = i_mid;
        n_win[8] = i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_adv) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    // neighbors inside the frame that carry a foreground color
    assign ok_row = {i_flags.ok_row_dn, 1'b1, i_flags.ok_row_up};
    assign ok_col = {i_flags.ok_col_rt, 1'b1, i_flags.ok_col_lf};
    assign center = n_win[4];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                hit[r*3 + c] = ok_row[r] && ok_col[c] && !(r == 1 && c == 1)
                               && (n_win[r*3 + c] != i_background)
                               && (n_win[r*3 + c] != i_contour);
            end
        end
    end

    assign o_draw  = (center == i_background) && (|hit);
    assign o_pixel = o_draw ? i_contour : center;

endmodule

@@ rtl/image_outline_contour_3x3.sv @@
// 3x3 outline filter, top level: counters, row stores, window stage, output register
// a beat passes the window stage, then the output register; results lag one row plus one pixel
// throughput: one beat per cycle unless output stalls; the row stores take one read and one write a cycle
// reset: synchronous active low; clears counters, window, config and valids, not the row stores
// depends on ioc3_pkg, ioc3_line_store, ioc3_window
module image_outline_contour_3x3 #(
    parameter int MAX_WIDTH  = ioc3_pkg::DefMaxWidth,
    parameter int MAX_HEIGHT = ioc3_pkg::DefMaxHeight
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [ioc3_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [ioc3_pkg::CfgDataW-1:0]   i_cfg_data,
    // input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_req_type,
    input  logic [ioc3_pkg::ColorW-1:0]     i_pixel_in,
    // output channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [ioc3_pkg::ColorW-1:0]     o_pixel_out,
    output logic                            o_contour_drawn,
    output logic                            o_last_of_frame
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int WNEED = $clog2(MAX_WIDTH + 1);
    localparam int HNEED = $clog2(MAX_HEIGHT + 3);
    localparam int WCMP  = (WNEED > ioc3_pkg::WidthRegW) ? WNEED : ioc3_pkg::WidthRegW;
    localparam int HCMP  = (HNEED > ioc3_pkg::HeightRegW) ? HNEED : ioc3_pkg::HeightRegW;

    // configuration registers
    logic [ioc3_pkg::WidthRegW-1:0]  r_cfg_width;
    logic [ioc3_pkg::HeightRegW-1:0] r_cfg_height;
    logic [ioc3_pkg::ColorW-1:0]     r_background;
    logic [ioc3_pkg::ColorW-1:0]     r_contour;

    // counters
    logic [CW-1:0] r_in_col;
    logic [RW-1:0] r_in_row;
    logic [CW-1:0] r_out_col;
    logic [RW-1:0] r_out_row;

    // window stage
    logic                        r_v2;
    ioc3_pkg::t_pos_flags        r_flags2;
    logic [ioc3_pkg::ColorW-1:0] r_data2;
    logic [CW-1:0]               r_idx2;

    // output register
    logic                        r_ov;
    logic [ioc3_pkg::ColorW-1:0] r_pixel;
    logic                        r_drawn;
    logic                        r_last;

    logic [WCMP-1:0]             w_reg;
    logic [WCMP-1:0]             w_eff;
    logic [HCMP-1:0]             h_reg;
    logic [HCMP-1:0]             h_eff;
    logic [WCMP-1:0]             in_col_p1;
    logic [WCMP-1:0]             out_col_p1;
    logic [HCMP-1:0]             in_row_x;
    logic [HCMP-1:0]             out_row_x;
    logic [HCMP-1:0]             out_row_p1;
    logic                        pixel_phase;
    logic                        drop;
    logic                        emit;
    logic                        frame_end;
    logic                        in_wrap;
    logic                        out_wrap;
    logic                        accept;
    logic                        s1_go;
    logic                        s2_adv;
    logic [ioc3_pkg::ColorW-1:0] data;
    ioc3_pkg::t_pos_flags        flags;
    logic [ioc3_pkg::ColorW-1:0] st_top;
    logic [ioc3_pkg::ColorW-1:0] st_mid;
    logic [ioc3_pkg::ColorW-1:0] win_pixel;
    logic                        win_draw;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= ioc3_pkg::RstWidth;
            r_cfg_height <= ioc3_pkg::RstHeight;
            r_background <= ioc3_pkg::RstBackground;
            r_contour    <= ioc3_pkg::RstContour;
        end else if (i_cfg_we) begin
            unique case (ioc3_pkg::t_cfg_idx'(i_cfg_idx))
                ioc3_pkg::CFG_IMAGE_WIDTH: begin
                    r_cfg_width <= i_cfg_data[ioc3_pkg::WidthRegW-1:0];
                end
                ioc3_pkg::CFG_IMAGE_HEIGHT: begin
                    r_cfg_height <= i_cfg_data[ioc3_pkg::HeightRegW-1:0];
                end
                ioc3_pkg::CFG_BACKGROUND: begin
                    r_background <= i_cfg_data[ioc3_pkg::ColorW-1:0];
                end
                ioc3_pkg::CFG_CONTOUR: begin
                    r_contour <= i_cfg_data[ioc3_pkg::ColorW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective frame size, zero maps to one and large values to the maximum
    assign w_reg = WCMP'(r_cfg_width);
    assign h_reg = HCMP'(r_cfg_height);
    assign w_eff = (r_cfg_width == '0) ? WCMP'(1)
                 : ((w_reg > WCMP'(MAX_WIDTH)) ? WCMP'(MAX_WIDTH) : w_reg);
    assign h_eff = (r_cfg_height == '0) ? HCMP'(1)
                 : ((h_reg > HCMP'(MAX_HEIGHT)) ? HCMP'(MAX_HEIGHT) : h_reg);

    // position decode of the current beat
    assign in_col_p1   = WCMP'(r_in_col) + WCMP'(1);
    assign out_col_p1  = WCMP'(r_out_col) + WCMP'(1);
    assign in_row_x    = HCMP'(r_in_row);
    assign out_row_x   = HCMP'(r_out_row);
    assign out_row_p1  = out_row_x + HCMP'(1);
    assign pixel_phase = in_row_x < h_eff;
    assign drop        = (i_req_type == ioc3_pkg::REQ_DRAIN) && pixel_phase;
    assign data        = ((i_req_type == ioc3_pkg::REQ_PIXEL) && pixel_phase) ? i_pixel_in : '0;
    assign emit        = ((in_row_x >= HCMP'(2)) || ((in_row_x == HCMP'(1)) && (r_in_col != '0)))
                         && (out_row_x < h_eff);
    assign frame_end   = in_row_x >= (h_eff + HCMP'(1));
    assign in_wrap     = in_col_p1 >= w_eff;
    assign out_wrap    = out_col_p1 >= w_eff;

    always_comb begin
        flags.emit      = emit;
        flags.ok_row_up = r_out_row != '0;
        flags.ok_row_dn = out_row_p1 < h_eff;
        flags.ok_col_lf = r_out_col != '0;
        flags.ok_col_rt = out_col_p1 < w_eff;
        flags.last      = (out_row_p1 >= h_eff) && out_wrap;
    end

    // handshake: a stalled result blocks only when the window stage is also full
    assign s2_adv  = r_v2 && (!r_ov || i_ready);
    assign o_ready = !r_v2 || !r_ov || i_ready;
    assign accept  = i_valid && o_ready;
    assign s1_go   = accept && !drop;

    // frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (s1_go) begin
            if (frame_end) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (in_wrap) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + RW'(1);
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
                if (emit) begin
                    if (out_wrap) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + RW'(1);
                    end else begin
                        r_out_col <= r_out_col + CW'(1);
                    end
                end
            end
        end
    end

    // window stage valid and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s1_go) begin
            r_v2 <= 1'b1;
        end else if (s2_adv) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_flags2 <= flags;
            r_data2  <= data;
            r_idx2   <= r_in_col;
        end
    end

    // row stores: read on an accepted beat that is not dropped, written as the beat leaves the window stage
    ioc3_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (s1_go),
        .i_rd_idx (r_in_col),
        .i_wr_en  (s2_adv),
        .i_wr_idx (r_idx2),
        .i_wr_top (st_mid),
        .i_wr_mid (r_data2),
        .o_top    (st_top),
        .o_mid    (st_mid)
    );

    ioc3_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (s2_adv),
        .i_top        (st_top),
        .i_mid        (st_mid),
        .i_data       (r_data2),
        .i_flags      (r_flags2),
        .i_background (r_background),
        .i_contour    (r_contour),
        .o_pixel      (win_pixel),
        .o_draw       (win_draw)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s2_adv && r_flags2.emit) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && r_flags2.emit) begin
            r_pixel <= win_pixel;
            r_drawn <= win_draw;
            r_last  <= r_flags2.last;
        end
    end

    assign o_valid         = r_ov;
    assign o_pixel_out     = r_pixel;
    assign o_contour_drawn = r_drawn;
    assign o_last_of_frame = r_last;

endmodule

@@ rtl/ioc3_checker.sv @@
// port-level checks of the 3x3 outline filter and their bind to the top level
// depends on ioc3_pkg and image_outline_contour_3x3
module ioc3_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [ioc3_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input logic [ioc3_pkg::CfgDataW-1:0]   i_cfg_data,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [ioc3_pkg::ColorW-1:0]     o_pixel_out,
    input logic                            o_contour_drawn
);

    logic [ioc3_pkg::ColorW-1:0] r_contour;

    // shadow of the contour color as written on the config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contour <= ioc3_pkg::RstContour;
        end else if (i_cfg_we && (i_cfg_idx == ioc3_pkg::CFG_CONTOUR)) begin
            r_contour <= i_cfg_data[ioc3_pkg::ColorW-1:0];
        end
    end

    // a drawn pixel carries the contour color
    a_drawn_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_contour_drawn) |-> (o_pixel_out == r_contour))
        else $error("drawn pixel differs from contour color");

    // input backpressure only while a result is held
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without a held result");

    // a fresh result must be matched by an input beat taken before it
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("result appeared without a matching beat");

    // a held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pixel_out)))
        else $error("held result changed");

endmodule

bind image_outline_contour_3x3 ioc3_checker u_ioc3_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_we        (i_cfg_we),
    .i_cfg_idx       (i_cfg_idx),
    .i_cfg_data      (i_cfg_data),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_pixel_out     (o_pixel_out),
    .o_contour_drawn (o_contour_drawn)
);

@@ tb/sv/image_outline_contour_3x3_tb.sv @@
// testbench for the 3x3 outline filter: directed frames and random frames with stalls
// a scoreboard class predicts every output pixel and checks it; depends on ioc3_pkg and the rtl
`timescale 1ns / 1ps

module image_outline_contour_3x3_tb;

    localparam int RandomBeats = 1560;
    localparam int HoldCycles  = 400;
    localparam int BurstFrom   = 600;
    localparam int BurstTo     = 1000;

    typedef logic [ioc3_pkg::ColorW-1:0]   t_color;
    typedef logic [ioc3_pkg::CfgDataW-1:0] t_cfg_word;

    // one expected output beat
    typedef struct packed {
        logic [ioc3_pkg::ColorW-1:0] pixel;
        logic                        drawn;
        logic                        last;
    } t_outline_px;

    // predictor of the outline filter plus the queue of pixels still due
    class t_contour_scoreboard;
        logic [ioc3_pkg::WidthRegW-1:0]  width_reg;
        logic [ioc3_pkg::HeightRegW-1:0] height_reg;
        logic [ioc3_pkg::ColorW-1:0]     back_rgb;
        logic [ioc3_pkg::ColorW-1:0]     outline_rgb;
        logic [ioc3_pkg::ColorW-1:0]     row_up  [ioc3_pkg::DefMaxWidth];
        logic [ioc3_pkg::ColorW-1:0]     row_mid [ioc3_pkg::DefMaxWidth];
        logic [ioc3_pkg::ColorW-1:0]     win     [9];
        int unsigned                     col_in, row_in, col_out, row_out;
        t_outline_px                     pixels_due[$];
        int unsigned                     n_taken, n_ignored, n_checked, n_drawn, n_frames;
        int unsigned                     n_errors;

        function new();
            width_reg   = ioc3_pkg::RstWidth;
            height_reg  = ioc3_pkg::RstHeight;
            back_rgb    = ioc3_pkg::RstBackground;
            outline_rgb = ioc3_pkg::RstContour;
            foreach (row_up[i]) begin
                row_up[i]  = '0;
                row_mid[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            col_in = 0; row_in = 0; col_out = 0; row_out = 0;
            n_taken = 0; n_ignored = 0; n_checked = 0;
            n_drawn = 0; n_frames = 0; n_errors = 0;
        endfunction

        function void write_reg(ioc3_pkg::t_cfg_idx idx, logic [ioc3_pkg::CfgDataW-1:0] data);
            unique case (idx)
                ioc3_pkg::CFG_IMAGE_WIDTH:  width_reg   = data[ioc3_pkg::WidthRegW-1:0];
                ioc3_pkg::CFG_IMAGE_HEIGHT: height_reg  = data[ioc3_pkg::HeightRegW-1:0];
                ioc3_pkg::CFG_BACKGROUND:   back_rgb    = data;
                ioc3_pkg::CFG_CONTOUR:      outline_rgb = data;
                default: ;
            endcase
        endfunction

        // effective frame size, zero and oversize values clamped
        function int unsigned frame_w();
            if (width_reg == 0) return 1;
            if (width_reg > ioc3_pkg::DefMaxWidth) return ioc3_pkg::DefMaxWidth;
            return width_reg;
        endfunction

        function int unsigned frame_h();
            if (height_reg == 0) return 1;
            if (height_reg > ioc3_pkg::DefMaxHeight) return ioc3_pkg::DefMaxHeight;
            return height_reg;
        endfunction

        function bit at_frame_start();
            return row_in == 0 && col_in == 0;
        endfunction

        function bit in_pixel_phase();
            return row_in < frame_h();
        endfunction

        // accepted input beat: update the mirror and queue the pixel it releases
        function void note_beat(logic req, logic [ioc3_pkg::ColorW-1:0] px);
            int unsigned                 w, h;
            logic [ioc3_pkg::ColorW-1:0] data, top, mid, center, v;
            bit                          ok_r[3], ok_c[3];
            bit                          draw;
            t_outline_px                 due;
            w = frame_w();
            h = frame_h();
            // a drain before the frame is complete is dropped
            if (req == ioc3_pkg::REQ_DRAIN && row_in < h) begin
                n_ignored++;
                return;
            end
            n_taken++;
            data = (req == ioc3_pkg::REQ_PIXEL && row_in < h) ? px : '0;

            // row stores, then window shift by one column
            top = row_up[col_in];
            mid = row_mid[col_in];
            row_up[col_in]  = mid;
            row_mid[col_in] = data;
            for (int r = 0; r < 3; r++) begin
                win[r*3]   = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = data;

            if ((row_in >= 2 || (row_in == 1 && col_in >= 1)) && row_out < h) begin
                center  = win[4];
                draw    = 1'b0;
                ok_r[0] = row_out > 0;
                ok_r[1] = 1'b1;
                ok_r[2] = row_out + 1 < h;
                ok_c[0] = col_out > 0;
                ok_c[1] = 1'b1;
                ok_c[2] = col_out + 1 < w;
                // background pixel next to a foreign color inside the frame
                if (center == back_rgb) begin
                    for (int r = 0; r < 3; r++) begin
                        for (int c = 0; c < 3; c++) begin
                            v = win[r*3+c];
                            if (!(r == 1 && c == 1) && ok_r[r] && ok_c[c] &&
                                v != back_rgb && v != outline_rgb) draw = 1'b1;
                        end
                    end
                end
                due.pixel = draw ? outline_rgb : center;
                due.drawn = draw;
                due.last  = (row_out + 1 >= h) && (col_out + 1 >= w);
                pixels_due = {pixels_due, due};
                if (col_out + 1 >= w) begin
                    col_out = 0;
                    row_out++;
                end else begin
                    col_out++;
                end
            end

            // last flush beat of the frame clears all positions
            if (row_in >= h + 1) begin
                col_in = 0; row_in = 0; col_out = 0; row_out = 0;
                n_frames++;
            end else if (col_in + 1 >= w) begin
                col_in = 0;
                row_in++;
            end else begin
                col_in++;
            end
        endfunction

        function void report(string what, logic [ioc3_pkg::ColorW-1:0] exp_v,
                             logic [ioc3_pkg::ColorW-1:0] act_v);
            n_errors++;
            $display("%0t: %s expected %06h got %06h", $time, what, exp_v, act_v);
        endfunction

        // accepted output beat against the oldest pixel due
        function void check_pixel(logic [ioc3_pkg::ColorW-1:0] pix, logic drawn, logic last);
            t_outline_px due;
            if (pixels_due.size() == 0) begin
                report("unexpected output beat, pixel_out", '0, pix);
                return;
            end
            due = pixels_due.pop_front();
            n_checked++;
            if (due.drawn) n_drawn++;
            if (pix !== due.pixel)   report("pixel_out", due.pixel, pix);
            if (drawn !== due.drawn) report("contour_drawn", 24'(due.drawn), 24'(drawn));
            if (last !== due.last)   report("last_of_frame", 24'(due.last), 24'(last));
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [ioc3_pkg::CfgIdxW-1:0]      i_cfg_idx;
    logic [ioc3_pkg::CfgDataW-1:0]     i_cfg_data;
    logic                              i_valid;
    logic                              o_ready;
    logic                              i_req_type;
    logic [ioc3_pkg::ColorW-1:0]       i_pixel_in;
    logic                              o_valid;
    logic                              i_ready;
    logic [ioc3_pkg::ColorW-1:0]       o_pixel_out;
    logic                              o_contour_drawn;
    logic                              o_last_of_frame;

    t_contour_scoreboard sb;
    bit                  idle_en  = 1'b1;
    bit                  hold_tgl = 1'b0;

    image_outline_contour_3x3 i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_req_type      (i_req_type),
        .i_pixel_in      (i_pixel_in),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_out     (o_pixel_out),
        .o_contour_drawn (o_contour_drawn),
        .o_last_of_frame (o_last_of_frame)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #400_000;
        $display("TEST FAILED");
        $finish;
    end

    // output side: random stalls, one long hold-off on request
    initial begin
        int unsigned held;
        bit          hold_seen;
        hold_seen = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_tgl != hold_seen) begin
                hold_seen = hold_tgl;
                i_ready <= 1'b0;
                for (held = 0; held < HoldCycles; held++) @(posedge i_clk);
            end else begin
                i_ready <= !(idle_en && $urandom_range(99) < 32);
            end
        end
    end

    // output beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_pixel(o_pixel_out, o_contour_drawn, o_last_of_frame);
    end

    // one input beat, optional gap before it; valid is left high on return
    task automatic send_beat(input logic req, input logic [ioc3_pkg::ColorW-1:0] px);
        while (idle_en && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_pixel_in <= px;
        do @(posedge i_clk); while (!o_ready);
        sb.note_beat(req, px);
    endtask

    // drop valid and wait for every pixel due plus the pipeline depth
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pixels_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic put_reg(input ioc3_pkg::t_cfg_idx idx,
                           input logic [ioc3_pkg::CfgDataW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_frame(input t_cfg_word w, input t_cfg_word h,
                             input t_cfg_word bg, input t_cfg_word ct);
        put_reg(ioc3_pkg::CFG_IMAGE_WIDTH, w);
        put_reg(ioc3_pkg::CFG_IMAGE_HEIGHT, h);
        put_reg(ioc3_pkg::CFG_BACKGROUND, bg);
        put_reg(ioc3_pkg::CFG_CONTOUR, ct);
        i_cfg_we <= 1'b0;
    endtask

    // background most often, some outline color, extremes and noise
    function automatic t_color pick_pixel();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45) return sb.back_rgb;
        if (r < 60) return sb.outline_rgb;
        if (r < 65) return '0;
        if (r < 70) return '1;
        return t_color'($urandom);
    endfunction

    // full frame and its flush; noisy adds dropped drains and pixels in the flush
    task automatic send_frame(input bit noisy);
        int unsigned w, h;
        w = sb.frame_w();
        h = sb.frame_h();
        for (int i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(99) < 8)
                send_beat(ioc3_pkg::REQ_DRAIN, t_color'($urandom));
            send_beat(ioc3_pkg::REQ_PIXEL, pick_pixel());
        end
        for (int i = 0; i <= w; i++)
            send_beat((noisy && $urandom_range(99) < 25) ? ioc3_pkg::REQ_PIXEL
                                                         : ioc3_pkg::REQ_DRAIN,
                      t_color'($urandom));
    endtask

    // complete whatever frame is open so registers can change
    task automatic finish_frame();
        while (!sb.at_frame_start())
            send_beat(sb.in_pixel_phase() ? ioc3_pkg::REQ_PIXEL : ioc3_pkg::REQ_DRAIN,
                      pick_pixel());
    endtask

    initial begin
        int unsigned base, w, h, k, m, style;
        t_color      bg, ct;
        bit          hold_done;
        hold_done = 1'b0;
        sb = new();
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_req_type <= ioc3_pkg::REQ_PIXEL;
        i_pixel_in <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= ioc3_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x3 frame, white background, black outline, drain inside the frame
        set_frame(24'd3, 24'd3, 24'hFFFFFF, 24'h000000);
        send_beat(ioc3_pkg::REQ_PIXEL, 24'hFFFFFF);
        send_beat(ioc3_pkg::REQ_PIXEL, 24'hFFFFFF);
        send_beat(ioc3_pkg::REQ_PIXEL, 24'h000000);
        send_beat(ioc3_pkg::REQ_PIXEL, 24'hFFFFFF);
        send_beat(ioc3_pkg::REQ_DRAIN, 24'hFFFFFF);
        send_beat(ioc3_pkg::REQ_PIXEL, 24'h123456);
        send_beat(ioc3_pkg::REQ_PIXEL, 24'hFFFFFF);
        send_beat(ioc3_pkg::REQ_PIXEL, 24'hFFFFFF);
        send_beat(ioc3_pkg::REQ_PIXEL, 24'hFFFFFF);
        send_beat(ioc3_pkg::REQ_PIXEL, 24'hFFFFFE);
        send_beat(ioc3_pkg::REQ_DRAIN, 24'h000000);
        send_beat(ioc3_pkg::REQ_PIXEL, 24'hABCDEF);
        send_beat(ioc3_pkg::REQ_DRAIN, 24'hFFFFFF);
        send_beat(ioc3_pkg::REQ_DRAIN, 24'h000000);
        settle();

        // zero width and height clamp to a single pixel
        set_frame(24'd0, 24'd0, 24'h00FF00, 24'h0000FF);
        send_beat(ioc3_pkg::REQ_PIXEL, 24'h00FF00);
        send_beat(ioc3_pkg::REQ_DRAIN, 24'h000000);
        send_beat(ioc3_pkg::REQ_DRAIN, 24'hFFFFFF);
        settle();

        // background equal to outline color
        set_frame(24'd2, 24'd2, 24'h5A5A5A, 24'h5A5A5A);
        send_beat(ioc3_pkg::REQ_PIXEL, 24'h5A5A5A);
        send_beat(ioc3_pkg::REQ_PIXEL, 24'hA5A5A5);
        send_beat(ioc3_pkg::REQ_PIXEL, 24'h5A5A5A);
        send_beat(ioc3_pkg::REQ_PIXEL, 24'h5A5A5A);
        send_beat(ioc3_pkg::REQ_DRAIN, 24'h000000);
        send_beat(ioc3_pkg::REQ_DRAIN, 24'h000000);
        send_beat(ioc3_pkg::REQ_DRAIN, 24'h000000);
        settle();

        // random frames: small sizes, mostly clean, some noisy or cut short
        base = sb.n_taken;
        while (sb.n_taken - base < RandomBeats) begin
            // a stretch in the middle runs with no idling on either side
            idle_en = !((sb.n_taken - base >= BurstFrom) && (sb.n_taken - base < BurstTo));
            if ($urandom_range(99) < 40) begin
                finish_frame();
                settle();
                w  = ($urandom_range(99) < 8) ? 0 : $urandom_range(12, 1);
                h  = ($urandom_range(99) < 5) ? 0 : $urandom_range(8, 1);
                bg = t_color'($urandom);
                if ($urandom_range(99) < 10) bg = '0;
                else if ($urandom_range(99) < 10) bg = '1;
                ct = ($urandom_range(99) < 15) ? bg : t_color'($urandom);
                set_frame(t_cfg_word'(w), t_cfg_word'(h), bg, ct);
            end
            // receiver held off once while the sender keeps offering beats
            if (!hold_done && sb.n_frames >= 8) begin
                hold_tgl  = !hold_tgl;
                hold_done = 1'b1;
            end
            style = $urandom_range(99);
            if (style < 75) begin
                send_frame(1'b0);
            end else if (style < 90) begin
                send_frame(1'b1);
            end else begin
                // partial frame, then a few beats of a short flush
                k = $urandom_range(sb.frame_w() * sb.frame_h(), 1);
                m = $urandom_range(sb.frame_w(), 0);
                for (int i = 0; i < k; i++) send_beat(ioc3_pkg::REQ_PIXEL, pick_pixel());
                for (int i = 0; i < m; i++)
                    send_beat(ioc3_pkg::REQ_DRAIN, t_color'($urandom));
            end
        end
        idle_en = 1'b1;
        finish_frame();
        settle();

        $display("covered %0d beats in %0d closed frames, %0d early drains dropped",
                 sb.n_taken, sb.n_frames, sb.n_ignored);
        $display("%0d output pixels checked, %0d of them outline, %0d mismatches",
                 sb.n_checked, sb.n_drawn, sb.n_errors);
        if (sb.n_errors == 0 && sb.pixels_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
